// ----- rtl/ymcp_pkg.sv -----
package ymcp_pkg;

  localparam int unsigned MID_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned CODE_W   = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned BCNT_W   = 3;

  localparam logic [CODE_W-1:0] CODE_FULL = 6'h3f;

  typedef struct packed {
    logic [SAMPLE_W-1:0] yellow;
    logic [SAMPLE_W-1:0] magenta;
    logic [SAMPLE_W-1:0] cyan;
    logic                end_of_image;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] yellow_byte;
    logic [BYTE_W-1:0] magenta_byte;
    logic [BYTE_W-1:0] cyan_byte;
    logic              planes_valid;
    logic [BYTE_W-1:0] black_byte;
    logic              black_valid;
    logic              last_out;
  } out_item_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [CODE_W-1:0] y_code;
    logic [CODE_W-1:0] m_code;
    logic [CODE_W-1:0] c_code;
    logic              black;
    logic              last;
    logic              extract_en;
  } mid_item_t;

endpackage

// ----- rtl/ymcp_fifo.sv -----
module ymcp_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned Depth  = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_data,
  input  logic  pop,
  output item_t rd_data,
  output logic  full,
  output logic  empty
);
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == CntW'(Depth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];

endmodule

// ----- rtl/ymcp_front.sv -----
module ymcp_front (
  input  ymcp_pkg::in_item_t  in_item,
  input  logic                extract_en,
  output ymcp_pkg::mid_item_t mid_item
);
  import ymcp_pkg::*;

  logic [CODE_W-1:0] y_c, m_c, c_c;
  logic              is_black;

  // drop the two low bits of each sample
  assign y_c = in_item.yellow[SAMPLE_W-1 -: CODE_W];
  assign m_c = in_item.magenta[SAMPLE_W-1 -: CODE_W];
  assign c_c = in_item.cyan[SAMPLE_W-1 -: CODE_W];

  assign is_black = extract_en && (y_c == CODE_FULL) && (m_c == CODE_FULL)
                    && (c_c == CODE_FULL);

  always_comb begin
    mid_item.y_code     = is_black ? '0 : y_c;
    mid_item.m_code     = is_black ? '0 : m_c;
    mid_item.c_code     = is_black ? '0 : c_c;
    mid_item.black      = is_black;
    mid_item.last       = in_item.end_of_image;
    mid_item.extract_en = extract_en;
  end

endmodule

// ----- rtl/ymcp_back.sv -----
module ymcp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ymcp_pkg::mid_item_t mid_item,
  input  logic                mid_valid,
  input  logic                out_room,
  output logic                mid_pop,
  output logic                out_push,
  output ymcp_pkg::out_item_t out_item
);
  import ymcp_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] done;
    logic [BYTE_W-1:0] part;
  } pack_res_t;

  // place one 6-bit code at the given phase of a 4-in-3 group, MSB first
  function automatic pack_res_t pack_one(input logic [PHASE_W-1:0] phase,
                                         input logic [CODE_W-1:0]  v,
                                         input logic [BYTE_W-1:0]  part);
    pack_res_t r;
    r.done = '0;
    r.part = '0;
    case (phase)
      2'd0: begin
        r.part = {v, 2'b00};
      end
      2'd1: begin
        r.done = {part[7:2], v[5:4]};
        r.part = {v[3:0], 4'b0000};
      end
      2'd2: begin
        r.done = {part[7:4], v[5:2]};
        r.part = {v[1:0], 6'b000000};
      end
      default: begin
        r.done = {part[7:6], v};
        r.part = '0;
      end
    endcase
    return r;
  endfunction

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [BYTE_W-1:0]  y_part_r, y_part_nxt;
  logic [BYTE_W-1:0]  m_part_r, m_part_nxt;
  logic [BYTE_W-1:0]  c_part_r, c_part_nxt;
  logic [BCNT_W-1:0]  bcnt_r, bcnt_nxt;
  logic [BYTE_W-1:0]  bacc_r, bacc_nxt;

  pack_res_t          y_res, m_res, c_res;
  logic               fire, group_mid, planes_ok, black_ok;
  logic [BCNT_W-1:0]  bcnt_inc;
  logic [BYTE_W-1:0]  bacc_set;

  assign fire    = mid_valid && out_room;
  assign mid_pop = fire;

  assign y_res = pack_one(phase_r, mid_item.y_code, y_part_r);
  assign m_res = pack_one(phase_r, mid_item.m_code, m_part_r);
  assign c_res = pack_one(phase_r, mid_item.c_code, c_part_r);

  assign group_mid = (phase_r != '0);
  assign planes_ok = group_mid || mid_item.last;

  assign bcnt_inc = bcnt_r + 1'b1;
  assign bacc_set = bacc_r | (BYTE_W'(mid_item.black) << bcnt_r);
  assign black_ok = mid_item.extract_en && ((bcnt_inc == '0) || mid_item.last);

  assign out_push = fire && (planes_ok || black_ok);

  always_comb begin
    out_item.yellow_byte  = '0;
    out_item.magenta_byte = '0;
    out_item.cyan_byte    = '0;
    out_item.black_byte   = '0;
    if (planes_ok) begin
      // a lone first code on the final pixel flushes its partial byte
      out_item.yellow_byte  = group_mid ? y_res.done : y_res.part;
      out_item.magenta_byte = group_mid ? m_res.done : m_res.part;
      out_item.cyan_byte    = group_mid ? c_res.done : c_res.part;
    end
    if (black_ok) begin
      out_item.black_byte = bacc_set;
    end
    out_item.planes_valid = planes_ok;
    out_item.black_valid  = black_ok;
    out_item.last_out     = mid_item.last;
  end

  always_comb begin
    phase_nxt  = phase_r;
    y_part_nxt = y_part_r;
    m_part_nxt = m_part_r;
    c_part_nxt = c_part_r;
    bcnt_nxt   = bcnt_r;
    bacc_nxt   = bacc_r;
    if (fire) begin
      if (mid_item.last) begin
        phase_nxt  = '0;
        y_part_nxt = '0;
        m_part_nxt = '0;
        c_part_nxt = '0;
        bcnt_nxt   = '0;
        bacc_nxt   = '0;
      end else begin
        phase_nxt  = phase_r + 1'b1;
        y_part_nxt = y_res.part;
        m_part_nxt = m_res.part;
        c_part_nxt = c_res.part;
        if (mid_item.extract_en) begin
          bcnt_nxt = bcnt_inc;
          bacc_nxt = (bcnt_inc == '0) ? '0 : bacc_set;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      y_part_r <= '0;
      m_part_r <= '0;
      c_part_r <= '0;
      bcnt_r   <= '0;
      bacc_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      y_part_r <= y_part_nxt;
      m_part_r <= m_part_nxt;
      c_part_r <= c_part_nxt;
      bcnt_r   <= bcnt_nxt;
      bacc_r   <= bacc_nxt;
    end
  end

endmodule

// ----- rtl/ymc_six_bit_packer_black_extract.sv -----
// Channel  | Ports                          | Beat taken when
// ---------+--------------------------------+-------------------------
// input    | in_push, in_full, in_data      | in_push && !in_full
// result   | out_empty, out_pop, out_data   | out_pop && !out_empty
// config   | cfg_we, cfg_wdata              | cfg_we
//
// One pixel per clock sustained while results drain. The front trims and
// classifies a pixel as it is pushed; the back packs one pixel per cycle
// from the mid queue while the output queue has room. Data passes the mid
// queue, then the output queue. Synchronous active-low reset empties both
// queues and clears packing state and black_extract; no clearing pass. A
// stalled result side fills the output queue, then the mid queue, then
// raises in_full; pixels that yield no result never enter it.
module ymc_six_bit_packer_black_extract #(
  parameter int unsigned MID_DEPTH = ymcp_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = ymcp_pkg::OUT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  ymcp_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output ymcp_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import ymcp_pkg::*;

  // black extraction enable; the user must hold it across the image, the block does not enforce this
  logic        extract_en_r;

  mid_item_t   front_item, mid_head;
  logic        mid_empty, mid_pop;
  out_item_t   back_item;
  logic        out_full, back_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extract_en_r <= 1'b0;
    end else if (cfg_we) begin
      extract_en_r <= cfg_wdata;
    end
  end

  // front: cut to 6 bits, spot full-density pixels
  ymcp_front u_front (
    .in_item    (in_data),
    .extract_en (extract_en_r),
    .mid_item   (front_item)
  );

  // short queue so the back can stall without blocking the pusher at once
  ymcp_fifo #(
    .item_t (mid_item_t),
    .Depth  (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (front_item),
    .pop     (mid_pop),
    .rd_data (mid_head),
    .full    (in_full),
    .empty   (mid_empty)
  );

  // back: plane packing, black accumulation, end-of-image flush
  ymcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_item  (mid_head),
    .mid_valid (!mid_empty),
    .out_room  (!out_full),
    .mid_pop   (mid_pop),
    .out_push  (back_push),
    .out_item  (back_item)
  );

  // result queue parts the back from the consumer
  ymcp_fifo #(
    .item_t (out_item_t),
    .Depth  (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (back_push),
    .wr_data (back_item),
    .pop     (out_pop),
    .rd_data (out_data),
    .full    (out_full),
    .empty   (out_empty)
  );

endmodule

// ----- rtl/ymcp_checker.sv -----
module ymcp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input ymcp_pkg::out_item_t out_data
);
  import ymcp_pkg::*;

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

  // every result carries plane or black data; the final one always planes
  a_content: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_data.planes_valid || out_data.black_valid)
                    && (!out_data.last_out || out_data.planes_valid)))
    else $error("result without content");

  // invalid plane bytes read as zero
  a_plane_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.planes_valid) |->
      (out_data.yellow_byte == '0 && out_data.magenta_byte == '0
       && out_data.cyan_byte == '0))
    else $error("plane bytes not zero when invalid");

  // invalid black byte reads as zero
  a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.black_valid) |-> (out_data.black_byte == '0))
    else $error("black byte not zero when invalid");

endmodule

bind ymc_six_bit_packer_black_extract ymcp_checker u_ymcp_checker (.*);
